// File: hdl/brpe_pkg.sv
// Package for the banked register file and exception unit.
// Holds item codes, field constants, controller command type and bank/condition helpers.
// No dependencies.
package brpe_pkg;

    // Item kinds.
    localparam logic [2:0] KIND_STEP      = 3'd0;
    localparam logic [2:0] KIND_READ_REG  = 3'd1;
    localparam logic [2:0] KIND_WRITE_REG = 3'd2;
    localparam logic [2:0] KIND_WRITE_PSR = 3'd3;
    localparam logic [2:0] KIND_EXCEPTION = 3'd4;

    // Exception codes for forced entry.
    localparam logic [2:0] EXC_RESET = 3'd0;
    localparam logic [2:0] EXC_IRQ   = 3'd6;
    localparam logic [2:0] EXC_FIQ   = 3'd7;

    // Processor modes.
    localparam logic [1:0] MODE_USR = 2'd0;
    localparam logic [1:0] MODE_FIQ = 2'd1;
    localparam logic [1:0] MODE_IRQ = 2'd2;
    localparam logic [1:0] MODE_SVC = 2'd3;

    // Vectors (byte addresses).
    localparam logic [4:0] VEC_PABORT = 5'h0C;
    localparam logic [4:0] VEC_IRQ    = 5'h18;
    localparam logic [4:0] VEC_FIQ    = 5'h1C;

    // Status register layout.
    localparam int          PSR_BIT_I = 27;
    localparam int          PSR_BIT_F = 26;
    localparam logic [31:0] PSR_RESET = 32'h0C00_0003;

    // Register bank geometry.
    localparam int          NUM_BANK  = 26;
    localparam int          BANK_AW   = $clog2(NUM_BANK);
    localparam logic [3:0]  REG_LINK  = 4'd14;
    localparam logic [3:0]  REG_PC    = 4'd15;

    // Word address width of the program counter.
    localparam int          PC_WW     = 24;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_DONE      = 3'd0,
        ACT_FIQ       = 3'd1,
        ACT_IRQ       = 3'd2,
        ACT_PABORT    = 3'd3,
        ACT_EXECUTE   = 3'd4,
        ACT_SKIPPED   = 3'd5,
        ACT_EXCEPTION = 3'd6
    } action_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

    // Physical bank slot for a mode and architectural register (r15 excluded).
    function automatic logic [BANK_AW-1:0] bank_index(input logic [1:0] mode,
                                                      input logic [3:0] r);
        logic [BANK_AW-1:0] base;
        base = {{(BANK_AW-4){1'b0}}, r};
        if (r < 4'd8) begin
            return base;
        end
        if (r < 4'd13) begin
            return (mode == MODE_FIQ) ? base + BANK_AW'(5) : base;
        end
        return base + BANK_AW'(5) + {{(BANK_AW-3){1'b0}}, mode, 1'b0};
    endfunction

    // Condition field check against N Z C V.
    function automatic logic cond_passes(input logic [3:0] flags, input logic [3:0] cond);
        logic n;
        logic z;
        logic c;
        logic v;
        logic pass;
        n = flags[3];
        z = flags[2];
        c = flags[1];
        v = flags[0];
        case (cond)
            4'd0:    pass = z;
            4'd1:    pass = !z;
            4'd2:    pass = c;
            4'd3:    pass = !c;
            4'd4:    pass = n;
            4'd5:    pass = !n;
            4'd6:    pass = v;
            4'd7:    pass = !v;
            4'd8:    pass = c && !z;
            4'd9:    pass = !(c && !z);
            4'd10:   pass = (n == v);
            4'd11:   pass = (n != v);
            4'd12:   pass = !z && (n == v);
            4'd13:   pass = !(!z && (n == v));
            4'd14:   pass = 1'b1;
            default: pass = 1'b0;
        endcase
        return pass;
    endfunction

endpackage

// File: hdl/brpe_ctrl.sv
// Controller for the banked register file and exception unit.
// Sequences capture and execute of one item; depends on brpe_pkg.
module brpe_ctrl
    import brpe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output ctl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Commands follow from the current state and the handshakes.
    always_comb
    begin
        cmd.capture    = in_valid && in_ready_reg;
        cmd.execute    = (state_reg == ST_BUSY) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next    = ST_BUSY;
                    in_ready_next = 1'b0;
                end
            end
            ST_BUSY:
            begin
                if (cmd.execute)
                begin
                    state_next     = ST_IDLE;
                    in_ready_next  = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/brpe_datapath.sv
// Datapath for the banked register file and exception unit.
// Holds the register bank, pc, psr, the captured item and the result register;
// depends on brpe_pkg.
module brpe_datapath
    import brpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    cmd,
    input  logic [2:0]  kind,
    input  logic [1:0]  reg_mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] value,
    input  logic [31:0] instruction,
    input  logic        prefetch_abort,
    input  logic        fiq_pending,
    input  logic        irq_pending,
    input  logic [2:0]  exception_code,
    output logic [2:0]  action,
    output logic [31:0] read_data,
    output logic [25:0] pc_value,
    output logic [31:0] psr_value,
    output logic        privileged
);

    // Captured item.
    logic [2:0]  kind_reg;
    logic [1:0]  mode_reg;
    logic [3:0]  index_reg;
    logic [31:0] value_reg;
    logic [3:0]  cond_reg;
    logic        pabort_reg;
    logic        fiq_reg;
    logic        irq_reg;
    logic [2:0]  code_reg;

    // Architectural state; the pc is kept as a word address.
    logic [31:0]      bank_reg [NUM_BANK];
    logic [PC_WW-1:0] pc_reg;
    logic [PC_WW-1:0] pc_next;
    logic [31:0]      psr_reg;
    logic [31:0]      psr_next;

    // Result register.
    action_t     action_reg;
    action_t     action_next;
    logic [31:0] rdata_reg;
    logic [31:0] rdata_next;

    // Exception entry controls.
    logic               exc_take;
    logic [1:0]         exc_mode;
    logic [4:0]         exc_vec;
    logic               exc_set_f;
    logic [31:0]        link_value;
    logic               bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [31:0]        bank_wdata;
    logic [BANK_AW-1:0] bank_raddr;
    logic [PC_WW-1:0]   pc_dec;
    logic [4:0]         vec_plus;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            mode_reg   <= reg_mode;
            index_reg  <= reg_index;
            value_reg  <= value;
            cond_reg   <= instruction[31:28];
            pabort_reg <= prefetch_abort;
            fiq_reg    <= fiq_pending;
            irq_reg    <= irq_pending;
            code_reg   <= exception_code;
        end
    end

    // Decide the item's effect.
    always_comb
    begin
        exc_take    = 1'b0;
        exc_mode    = MODE_SVC;
        exc_vec     = VEC_PABORT;
        exc_set_f   = 1'b0;
        action_next = ACT_DONE;
        rdata_next  = 32'd0;
        pc_next     = pc_reg;
        psr_next    = psr_reg;
        bank_we     = 1'b0;
        bank_waddr  = bank_index(mode_reg, index_reg);
        bank_wdata  = value_reg;
        bank_raddr  = bank_index(mode_reg, index_reg);
        case (kind_reg)
            KIND_STEP:
            begin
                if (!psr_reg[PSR_BIT_F] && fiq_reg)
                begin
                    exc_take    = 1'b1;
                    exc_mode    = MODE_FIQ;
                    exc_vec     = VEC_FIQ;
                    exc_set_f   = 1'b1;
                    action_next = ACT_FIQ;
                end
                else if (!psr_reg[PSR_BIT_I] && irq_reg)
                begin
                    exc_take    = 1'b1;
                    exc_mode    = MODE_IRQ;
                    exc_vec     = VEC_IRQ;
                    action_next = ACT_IRQ;
                end
                else if (pabort_reg)
                begin
                    exc_take    = 1'b1;
                    action_next = ACT_PABORT;
                end
                else if (cond_passes(psr_reg[31:28], cond_reg))
                begin
                    action_next = ACT_EXECUTE;
                end
                else
                begin
                    pc_next     = pc_reg + PC_WW'(1);
                    action_next = ACT_SKIPPED;
                end
            end
            KIND_READ_REG:
            begin
                if (index_reg == REG_PC)
                begin
                    rdata_next = {6'd0, pc_reg, 2'b00};
                end
                else
                begin
                    rdata_next = bank_reg[bank_raddr];
                end
            end
            KIND_WRITE_REG:
            begin
                if (index_reg == REG_PC)
                begin
                    pc_next = value_reg[25:2];
                end
                else
                begin
                    bank_we = 1'b1;
                end
            end
            KIND_WRITE_PSR:
            begin
                if (psr_reg[1:0] == MODE_USR)
                begin
                    psr_next[31:28] = value_reg[31:28];
                end
                else
                begin
                    psr_next[31:26] = value_reg[31:26];
                    psr_next[1:0]   = value_reg[1:0];
                end
            end
            KIND_EXCEPTION:
            begin
                exc_take    = 1'b1;
                action_next = ACT_EXCEPTION;
                if (code_reg == EXC_FIQ)
                begin
                    exc_mode  = MODE_FIQ;
                    exc_vec   = VEC_FIQ;
                    exc_set_f = 1'b1;
                end
                else if (code_reg == EXC_IRQ)
                begin
                    exc_mode = MODE_IRQ;
                    exc_vec  = VEC_IRQ;
                end
                else
                begin
                    exc_vec   = {code_reg, 2'b00};
                    exc_set_f = (code_reg == EXC_RESET);
                end
            end
            default:
            begin
                action_next = ACT_DONE;
            end
        endcase

        // Exception entry: save link, switch mode, mask interrupts, jump two words past the vector.
        if (exc_take)
        begin
            bank_we    = 1'b1;
            bank_waddr = bank_index(exc_mode, REG_LINK);
            bank_wdata = link_value;
            psr_next   = {psr_reg[31:28], 1'b1, psr_reg[PSR_BIT_F] | exc_set_f,
                          psr_reg[25:2], exc_mode};
            pc_next    = {{(PC_WW-3){1'b0}}, vec_plus[4:2]} + PC_WW'(2);
        end
    end

    // Link value: byte address of pc minus one word, plus the full status register.
    assign pc_dec     = pc_reg - PC_WW'(1);
    assign link_value = {6'd0, pc_dec, 2'b00} + psr_reg;
    assign vec_plus   = exc_vec;

    // State update and result capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BANK; i++)
            begin
                bank_reg[i] <= 32'd0;
            end
            pc_reg  <= '0;
            psr_reg <= PSR_RESET;
        end
        else if (cmd.execute)
        begin
            if (bank_we)
            begin
                bank_reg[bank_waddr] <= bank_wdata;
            end
            pc_reg  <= pc_next;
            psr_reg <= psr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            action_reg <= action_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign action     = action_reg;
    assign read_data  = rdata_reg;
    assign pc_value   = {pc_reg, 2'b00};
    assign psr_value  = psr_reg;
    assign privileged = (psr_reg[1:0] != MODE_USR);

endmodule

// File: hdl/banked_regfile_psr_exception_unit.sv
// Top level of the banked register file, PC/PSR and exception front end.
// Instantiates brpe_ctrl and brpe_datapath; depends on brpe_pkg.
//
// Each input transfer is one item: a step slot (interrupt, prefetch abort and condition
// check), a register read or write through the mode banks, a status register write or
// a forced exception entry. Every item yields exactly one result carrying the action,
// read data, the pc and psr after the item, and the privileged flag. Each item is first
// captured; then the datapath applies it to the register bank, pc and psr and loads the
// result register. The result register lets the next item be taken while a result still
// waits; a stalled result holds the execute step, and no new item is taken before the
// last one has been applied. After reset the bank is zero, the pc is zero and the psr is
// supervisor mode with I and F set.
module banked_regfile_psr_exception_unit
    import brpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [1:0]  reg_mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] value,
    input  logic [31:0] instruction,
    input  logic        prefetch_abort,
    input  logic        fiq_pending,
    input  logic        irq_pending,
    input  logic [2:0]  exception_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [31:0] read_data,
    output logic [25:0] pc_value,
    output logic [31:0] psr_value,
    output logic        privileged
);

    ctl_cmd_t cmd;

    // Sequencing of capture and execute.
    brpe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Register bank, pc, psr and result register.
    brpe_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .reg_mode       (reg_mode),
        .reg_index      (reg_index),
        .value          (value),
        .instruction    (instruction),
        .prefetch_abort (prefetch_abort),
        .fiq_pending    (fiq_pending),
        .irq_pending    (irq_pending),
        .exception_code (exception_code),
        .action         (action),
        .read_data      (read_data),
        .pc_value       (pc_value),
        .psr_value      (psr_value),
        .privileged     (privileged)
    );

endmodule

// File: hdl/brpe_checker.sv
// Port-level checker for the banked register file and exception unit.
// Bound to banked_regfile_psr_exception_unit; no package dependencies.
module brpe_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  action,
    input logic [31:0] read_data,
    input logic [25:0] pc_value,
    input logic [31:0] psr_value,
    input logic        privileged
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(read_data)
            && $stable(pc_value) && $stable(psr_value))
        else $error("stalled result changed");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // With the output side free, the result appears once the item has been executed.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (!out_valid || out_ready) |-> ##2 out_valid)
        else $error("result did not appear in time");

    // The privileged flag follows the mode bits of the status register.
    a_priv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> privileged == (psr_value[1:0] != 2'd0))
        else $error("privileged flag disagrees with psr mode");

    // The pc is always word aligned.
    a_pc_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pc_value[1:0] == 2'b00)
        else $error("pc not word aligned");

endmodule

bind banked_regfile_psr_exception_unit brpe_port_checker u_brpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .action     (action),
    .read_data  (read_data),
    .pc_value   (pc_value),
    .psr_value  (psr_value),
    .privileged (privileged)
);

// File: tb/brpe_checker.sv
`timescale 1ns / 100ps
// Checker for the banked register file, PC/PSR and exception unit: keeps its own copy of the
// bank, pc and psr, works out one result per input transfer and compares each result field.
// Depends on brpe_pkg.
module brpe_checker
    import brpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [1:0]  reg_mode,
    input  logic [3:0]  reg_index,
    input  logic [31:0] value,
    input  logic [31:0] instruction,
    input  logic        prefetch_abort,
    input  logic        fiq_pending,
    input  logic        irq_pending,
    input  logic [2:0]  exception_code,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  action,
    input  logic [31:0] read_data,
    input  logic [25:0] pc_value,
    input  logic [31:0] psr_value,
    input  logic        privileged,
    output int          mismatches,
    output int          outstanding
);

    // Address field of the combined pc/psr word and the psr fields that each mode may write.
    localparam logic [31:0] PC_FIELD   = 32'h03FF_FFFC;
    localparam logic [31:0] USER_FIELD = 32'hF000_0000;
    localparam logic [31:0] PRIV_FIELD = 32'hFC00_0000;

    // First register banked in fiq mode, and the first one banked in every mode.
    localparam logic [3:0] REG_FIQ_LO = 4'd8;
    localparam logic [3:0] REG_SP     = 4'd13;

    // Condition field encodings.
    typedef enum logic [3:0] {
        COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
        COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
    } cond_t;

    typedef struct packed {
        action_t     act;
        logic [31:0] rdata;
        logic [25:0] pc;
        logic [31:0] psr;
        logic        priv;
    } fe_result_t;

    logic [31:0] bank_mem [NUM_BANK];
    logic [31:0] pc_q;
    logic [31:0] psr_q;
    fe_result_t  front_end_results [$];
    int          fail_count  = 0;
    int          queue_depth = 0;

    assign mismatches  = fail_count;
    assign outstanding = queue_depth;

    // Physical slot of an architectural register r0..r14 in a given mode.
    function automatic logic [4:0] bank_slot(input logic [1:0] mode, input logic [3:0] r);
        logic [4:0] slot;
        slot = {1'b0, r};
        if (r >= REG_SP) begin
            slot = slot + 5'd5 + {2'b00, mode, 1'b0};
        end else if (r >= REG_FIQ_LO && mode == MODE_FIQ) begin
            slot = slot + 5'd5;
        end
        return slot;
    endfunction

    // Condition check against the N Z C V flags.
    function automatic logic cond_met(input logic [3:0] flags, input logic [3:0] cond);
        logic n;
        logic z;
        logic c;
        logic v;
        n = flags[3];
        z = flags[2];
        c = flags[1];
        v = flags[0];
        case (cond_t'(cond))
            COND_EQ: return z;
            COND_NE: return !z;
            COND_CS: return c;
            COND_CC: return !c;
            COND_MI: return n;
            COND_PL: return !n;
            COND_VS: return v;
            COND_VC: return !v;
            COND_HI: return c && !z;
            COND_LS: return !(c && !z);
            COND_GE: return n == v;
            COND_LT: return n != v;
            COND_GT: return !z && (n == v);
            COND_LE: return !(!z && (n == v));
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Exception entry: the link word is the previous address plus the whole psr.
    function automatic void enter_trap(input logic [1:0] mode, input logic [31:0] vector,
                                       input logic set_f);
        logic [31:0] link;
        link = ((pc_q - 32'd4) & PC_FIELD) + psr_q;
        bank_mem[bank_slot(mode, REG_LINK)] = link;
        psr_q[1:0] = mode;
        psr_q[PSR_BIT_I] = 1'b1;
        if (set_f) begin
            psr_q[PSR_BIT_F] = 1'b1;
        end
        pc_q = (vector + 32'd8) & PC_FIELD;
    endfunction

    // Applies the item on the input ports to the state and returns its result.
    function automatic fe_result_t run_front_end();
        fe_result_t res;
        res.act   = ACT_DONE;
        res.rdata = '0;
        case (kind)
            KIND_STEP: begin
                // Fast interrupt wins over normal interrupt, then prefetch abort.
                if (!psr_q[PSR_BIT_F] && fiq_pending) begin
                    enter_trap(MODE_FIQ, 32'(VEC_FIQ), 1'b1);
                    res.act = ACT_FIQ;
                end else if (!psr_q[PSR_BIT_I] && irq_pending) begin
                    enter_trap(MODE_IRQ, 32'(VEC_IRQ), 1'b0);
                    res.act = ACT_IRQ;
                end else if (prefetch_abort) begin
                    enter_trap(MODE_SVC, 32'(VEC_PABORT), 1'b0);
                    res.act = ACT_PABORT;
                end else if (cond_met(psr_q[31:28], instruction[31:28])) begin
                    res.act = ACT_EXECUTE;
                end else begin
                    pc_q    = (pc_q + 32'd4) & PC_FIELD;
                    res.act = ACT_SKIPPED;
                end
            end
            KIND_READ_REG: begin
                res.rdata = (reg_index == REG_PC) ? pc_q : bank_mem[bank_slot(reg_mode, reg_index)];
            end
            KIND_WRITE_REG: begin
                if (reg_index == REG_PC) begin
                    pc_q = value & PC_FIELD;
                end else begin
                    bank_mem[bank_slot(reg_mode, reg_index)] = value;
                end
            end
            KIND_WRITE_PSR: begin
                // User mode may only change the flags.
                if (psr_q[1:0] == MODE_USR) begin
                    psr_q = (psr_q & ~USER_FIELD) | (value & USER_FIELD);
                end else begin
                    psr_q      = (psr_q & ~PRIV_FIELD) | (value & PRIV_FIELD);
                    psr_q[1:0] = value[1:0];
                end
            end
            KIND_EXCEPTION: begin
                if (exception_code == EXC_FIQ) begin
                    enter_trap(MODE_FIQ, 32'(VEC_FIQ), 1'b1);
                end else if (exception_code == EXC_IRQ) begin
                    enter_trap(MODE_IRQ, 32'(VEC_IRQ), 1'b0);
                end else begin
                    enter_trap(MODE_SVC, {27'd0, exception_code, 2'b00},
                               exception_code == EXC_RESET);
                end
                res.act = ACT_EXCEPTION;
            end
            default: begin
            end
        endcase
        res.pc   = pc_q[25:0];
        res.psr  = psr_q;
        res.priv = (psr_q[1:0] != MODE_USR);
        return res;
    endfunction

    // Counts one field mismatch; only the first few are printed.
    function automatic void note_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            if (fail_count < 10) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
            fail_count++;
        end
    endfunction

    // Inputs and results are sampled at the same edge at which they transfer.
    always @(posedge clk) begin : track
        fe_result_t want;
        if (!rst_n) begin
            foreach (bank_mem[i]) begin
                bank_mem[i] = '0;
            end
            pc_q  = '0;
            psr_q = PSR_RESET;
            front_end_results.delete();
        end else begin
            if (in_valid && in_ready) begin
                front_end_results.push_back(run_front_end());
            end
            if (out_valid && out_ready) begin
                if (front_end_results.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: result transfer with no item outstanding", $time);
                    end
                    fail_count++;
                end else begin
                    want = front_end_results.pop_front();
                    note_field("action", 32'(want.act), 32'(action));
                    note_field("read_data", want.rdata, read_data);
                    note_field("pc_value", 32'(want.pc), 32'(pc_value));
                    note_field("psr_value", want.psr, psr_value);
                    note_field("privileged", 32'(want.priv), 32'(privileged));
                end
            end
        end
        queue_depth = front_end_results.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for banked_regfile_psr_exception_unit: clock, reset, item stimulus,
// result back-pressure and the verdict. Depends on brpe_pkg and brpe_checker.
module testbench;
    import brpe_pkg::*;

    // Condition fields used by the directed items.
    localparam logic [3:0] COND_ALWAYS = 4'hE;
    localparam logic [3:0] COND_NEVER  = 4'hF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  reg_mode;
        logic [3:0]  reg_index;
        logic [31:0] value;
        logic [31:0] instruction;
        logic        prefetch_abort;
        logic        fiq_pending;
        logic        irq_pending;
        logic [2:0]  exception_code;
    } fe_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  kind;
    logic [1:0]  reg_mode;
    logic [3:0]  reg_index;
    logic [31:0] value;
    logic [31:0] instruction;
    logic        prefetch_abort;
    logic        fiq_pending;
    logic        irq_pending;
    logic [2:0]  exception_code;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  action;
    logic [31:0] read_data;
    logic [25:0] pc_value;
    logic [31:0] psr_value;
    logic        privileged;
    int          mismatches;
    int          outstanding;

    int          idle_pct    = 0;
    int          stall_pct   = 0;
    logic        pressure_on = 1'b0;
    logic        hold_out    = 1'b0;

    banked_regfile_psr_exception_unit dut (.*);

    brpe_checker u_checker (.*);

    always #5 clk = ~clk;

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("FAIL banked_regfile_psr_exception_unit");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off while the sender keeps going.
    always @(posedge clk) begin
        out_ready <= !hold_out && ($urandom_range(99) >= stall_pct);
    end

    initial begin : long_hold
        wait (pressure_on);
        hold_out <= 1'b1;
        repeat (300) @(posedge clk);
        hold_out <= 1'b0;
    end

    // Offers one item, with random idle cycles ahead of it, and returns once it transfers.
    task automatic offer(input fe_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= it.kind;
        reg_mode       <= it.reg_mode;
        reg_index      <= it.reg_index;
        value          <= it.value;
        instruction    <= it.instruction;
        prefetch_abort <= it.prefetch_abort;
        fiq_pending    <= it.fiq_pending;
        irq_pending    <= it.irq_pending;
        exception_code <= it.exception_code;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    function automatic fe_item_t make_item(input logic [2:0] k, input logic [1:0] m,
                                           input logic [3:0] r, input logic [31:0] v,
                                           input logic [31:0] ins, input logic pa,
                                           input logic fq, input logic iq,
                                           input logic [2:0] code);
        fe_item_t it;
        it.kind           = k;
        it.reg_mode       = m;
        it.reg_index      = r;
        it.value          = v;
        it.instruction    = ins;
        it.prefetch_abort = pa;
        it.fiq_pending    = fq;
        it.irq_pending    = iq;
        it.exception_code = code;
        return it;
    endfunction

    // Random item: mostly steps and register traffic, with psr writes that unmask interrupts
    // and drop to user mode often enough, and forced exceptions that bring it back.
    function automatic fe_item_t random_item();
        fe_item_t it;
        int       roll;
        roll = $urandom_range(99);
        if (roll < 35) begin
            it.kind = KIND_STEP;
        end else if (roll < 52) begin
            it.kind = KIND_READ_REG;
        end else if (roll < 67) begin
            it.kind = KIND_WRITE_REG;
        end else if (roll < 80) begin
            it.kind = KIND_WRITE_PSR;
        end else if (roll < 93) begin
            it.kind = KIND_EXCEPTION;
        end else begin
            it.kind = 3'($urandom_range(7, 32'(KIND_EXCEPTION) + 1));
        end
        it.reg_mode  = 2'($urandom_range(3));
        it.reg_index = 4'($urandom);
        roll = $urandom_range(9);
        if (roll == 0) begin
            it.value = '0;
        end else if (roll == 1) begin
            it.value = '1;
        end else begin
            it.value = $urandom;
        end
        it.instruction    = $urandom;
        it.prefetch_abort = ($urandom_range(9) == 0);
        it.fiq_pending    = ($urandom_range(99) < 30);
        it.irq_pending    = ($urandom_range(99) < 30);
        it.exception_code = 3'($urandom);
        return it;
    endfunction

    initial begin : stimulus
        int ph;
        int n;
        int code;
        int k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = '0;
        reg_mode       = '0;
        reg_index      = '0;
        value          = '0;
        instruction    = '0;
        prefetch_abort = 1'b0;
        fiq_pending    = 1'b0;
        irq_pending    = 1'b0;
        exception_code = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register file: pc write masking, fiq banking of r8..r14.
        offer(make_item(KIND_WRITE_REG, MODE_SVC, REG_PC, '1, '0, 1'b0, 1'b0, 1'b0, '0));
        offer(make_item(KIND_WRITE_REG, MODE_FIQ, REG_LINK, '1, '0, 1'b0, 1'b0, 1'b0, '0));
        offer(make_item(KIND_READ_REG, MODE_FIQ, REG_LINK, '0, '0, 1'b0, 1'b0, 1'b0, '0));
        offer(make_item(KIND_WRITE_REG, MODE_FIQ, 4'd8, 32'hA5A5_5A5A, '0, 1'b0, 1'b0, 1'b0,
                        '0));
        offer(make_item(KIND_READ_REG, MODE_USR, 4'd8, '0, '0, 1'b0, 1'b0, 1'b0, '0));

        // Steps: masked interrupts, the never condition with pc wrap, prefetch abort.
        offer(make_item(KIND_STEP, MODE_USR, '0, '0, {COND_ALWAYS, 28'h0}, 1'b0, 1'b1, 1'b1,
                        '0));
        offer(make_item(KIND_STEP, MODE_USR, '0, '0, {COND_NEVER, 28'hFFF_FFFF}, 1'b0, 1'b0,
                        1'b0, '0));
        offer(make_item(KIND_STEP, MODE_USR, '0, '0, {COND_ALWAYS, 28'h0}, 1'b1, 1'b0, 1'b0,
                        '0));

        // Privileged psr write unmasks, then fiq and irq are taken in turn.
        offer(make_item(KIND_WRITE_PSR, MODE_USR, '0, 32'hF000_0001, '0, 1'b0, 1'b0, 1'b0,
                        '0));
        offer(make_item(KIND_STEP, MODE_USR, '0, '0, {COND_ALWAYS, 28'h0}, 1'b0, 1'b1, 1'b1,
                        '0));
        offer(make_item(KIND_WRITE_PSR, MODE_USR, '0, 32'h0000_0002, '0, 1'b0, 1'b0, 1'b0,
                        '0));
        offer(make_item(KIND_STEP, MODE_USR, '0, '0, {COND_ALWAYS, 28'h0}, 1'b0, 1'b0, 1'b1,
                        '0));

        // Drop to user mode, then try to set every psr bit from there.
        offer(make_item(KIND_WRITE_PSR, MODE_USR, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0));
        offer(make_item(KIND_WRITE_PSR, MODE_USR, '0, '1, '0, 1'b0, 1'b0, 1'b0, '0));

        // Every forced exception, then the unused kinds.
        for (code = 0; code < 8; code++) begin
            offer(make_item(KIND_EXCEPTION, MODE_USR, '0, '0, '0, 1'b0, 1'b0, 1'b0, 3'(code)));
        end
        for (k = 32'(KIND_EXCEPTION) + 1; k < 8; k++) begin
            offer(make_item(3'(k), MODE_FIQ, REG_LINK, '1, '1, 1'b1, 1'b1, 1'b1, '1));
        end

        // Random items over the idling phases; the long hold-off lands in the first one.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    pressure_on <= 1'b1;
                end
                1: begin
                    idle_pct = 73;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 73;
                end
                default: begin
                    idle_pct = 34;
                    stall_pct <= 34;
                end
            endcase
            for (n = 0; n < 385; n++) begin
                offer(random_item());
            end
        end
        in_valid <= 1'b0;

        // Drain the remaining results, then allow for the block's latency.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS banked_regfile_psr_exception_unit");
        end else begin
            $display("FAIL banked_regfile_psr_exception_unit");
        end
        $finish;
    end

endmodule
